// File: rtl/saturating_fixed_point_dot_product_core_macros.svh
// Assertion macros used by the checker file.
`ifndef SATURATING_FIXED_POINT_DOT_PRODUCT_CORE_MACROS_SVH
`define SATURATING_FIXED_POINT_DOT_PRODUCT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFDP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sfdp assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define SFDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sfdp assertion failed: next-cycle implication");

`endif

// File: rtl/sfdp_pkg.sv
`default_nettype none

package sfdp_pkg;

	// Field widths at the ports
	localparam int WEIGHT_W = 16;
	localparam int SAMPLE_W = 16;
	localparam int OUT_W    = 32;

	// Operand and accumulator formats (WEIGHT_WIDTH <= WEIGHT_W, DATA_WIDTH <= SAMPLE_W)
	localparam int WEIGHT_WIDTH = 16;
	localparam int WEIGHT_FRAC  = 12;
	localparam int DATA_WIDTH   = 16;
	localparam int DATA_FRAC    = 8;
	localparam int ACC_WIDTH    = 32;
	localparam int ACC_FRAC     = 16;

	// Derived widths and alignment
	localparam int PROD_W = WEIGHT_WIDTH + DATA_WIDTH;
	localparam int SHIFT  = WEIGHT_FRAC + DATA_FRAC - ACC_FRAC;
	localparam int POS_SH = (SHIFT > 0) ? SHIFT : 0;
	localparam int NEG_SH = (SHIFT < 0) ? -SHIFT : 0;
	localparam int TOT_W  = ((ACC_WIDTH + POS_SH > PROD_W + NEG_SH) ?
		(ACC_WIDTH + POS_SH) : (PROD_W + NEG_SH)) + 1;
	localparam int EXT_W  = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;

	typedef logic signed [WEIGHT_W-1:0] weight_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [OUT_W-1:0]    sum_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_WIDTH-1:0] acc_t;

	// Operand stage contents
	typedef struct packed {
		weight_t weight;
		sample_t sample;
		logic    last;
	} pair_t;

	// Product stage contents
	typedef struct packed {
		prod_t prod;
		logic  last;
	} prod_stage_t;

endpackage

`default_nettype wire

// File: rtl/sfdp_if.sv
`default_nettype none

// Operand pair channel
interface sfdp_pair_if;
	import sfdp_pkg::*;

	logic    valid;
	logic    ready;
	weight_t weight;
	sample_t sample;
	logic    last;

	modport source (output valid, output weight, output sample, output last, input ready);
	modport sink   (input valid, input weight, input sample, input last, output ready);
endinterface

// Dot product result channel
interface sfdp_sum_if;
	import sfdp_pkg::*;

	logic valid;
	logic ready;
	sum_t dot_sum;

	modport source (output valid, output dot_sum, input ready);
	modport sink   (input valid, input dot_sum, output ready);
endinterface

`default_nettype wire

// File: rtl/saturating_fixed_point_dot_product_core.sv
// Saturating fixed-point multiply-accumulate for one element of a matrix product.
// pair_in carries a signed weight, a signed sample and a last flag; a pair
// transfers when valid and ready are both high. Each pair's exact product is
// added to the accumulator, rounded half-to-even to the accumulator's fraction
// bits and saturated. On a pair flagged last, sum_out presents the sum as
// dot_sum and the accumulator returns to zero; other pairs give no result.
// Throughput: one pair per cycle while no last pair waits on a stalled sum_out.
// A last pair passes the operand register, then the product register, then is
// accumulated into the result register. The accumulate step is a loop of add,
// round and clamp on the product, closed through the accumulator register.
// When sum_out stalls, pairs that are not last keep flowing into the
// accumulator; a last pair waits in the product stage until the result
// register frees, and the stages behind it fill before pair_in.ready drops.
// Reset (arst_n low) empties all stages, drops sum_out.valid and clears the
// accumulator; pair_in.ready is high straight after reset.
`default_nettype none

module saturating_fixed_point_dot_product_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sfdp_pair_if.sink  pair_in,
	sfdp_sum_if.source sum_out
);
	import sfdp_pkg::*;

	pair_t       op_s1;
	logic        op_valid_s1;
	prod_stage_t pr_s2;
	logic        pr_valid_s2;
	acc_t        acc_q;
	sum_t        sum_q;
	logic        sum_valid_q;

	logic        consume;
	logic        ready_s2;
	logic        ready_s1;
	acc_t        acc_next;
	logic signed [EXT_W-1:0] acc_ext;

	// Stage enables: only a last pair needs the result register free
	assign consume  = pr_valid_s2 && (!pr_s2.last || !sum_valid_q || sum_out.ready);
	assign ready_s2 = !pr_valid_s2 || consume;
	assign ready_s1 = !op_valid_s1 || ready_s2;
	assign pair_in.ready = ready_s1;

	// Operand register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			op_valid_s1 <= pair_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && pair_in.valid) begin
			op_s1.weight <= pair_in.weight;
			op_s1.sample <= pair_in.sample;
			op_s1.last   <= pair_in.last;
		end
	end

	// Product register: operands taken from their low bits as signed values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			pr_valid_s2 <= op_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && op_valid_s1) begin
			pr_s2.prod <= PROD_W'(signed'(op_s1.weight[WEIGHT_WIDTH-1:0]))
				* PROD_W'(signed'(op_s1.sample[DATA_WIDTH-1:0]));
			pr_s2.last <= op_s1.last;
		end
	end

	// Align, add, round half-to-even and clamp
	logic signed [TOT_W-1:0] total;
	logic signed [TOT_W-1:0] rnd;
	logic signed [TOT_W-1:0] sat_hi;
	logic signed [TOT_W-1:0] sat_lo;

	assign total = (TOT_W'(acc_q) <<< POS_SH) + (TOT_W'(pr_s2.prod) <<< NEG_SH);
	assign sat_hi = {{(TOT_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
	assign sat_lo = ~sat_hi;

	generate
		if (POS_SH > 0) begin : g_round
			logic signed [TOT_W-1:0] quo;
			logic [POS_SH-1:0]       rem;
			logic [POS_SH-1:0]       half;
			logic                    inc;

			assign quo  = total >>> POS_SH;
			assign rem  = total[POS_SH-1:0];
			assign half = {1'b1, {(POS_SH - 1){1'b0}}};
			assign inc  = (rem > half) || ((rem == half) && quo[0]);
			assign rnd  = quo + TOT_W'(inc);
		end else begin : g_exact
			assign rnd = total;
		end
	endgenerate

	always_comb begin
		priority if (rnd > sat_hi) begin
			acc_next = sat_hi[ACC_WIDTH-1:0];
		end else if (rnd < sat_lo) begin
			acc_next = sat_lo[ACC_WIDTH-1:0];
		end else begin
			acc_next = rnd[ACC_WIDTH-1:0];
		end
	end

	assign acc_ext = EXT_W'(acc_next);

	// Accumulator: clear after a last pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (consume) begin
			acc_q <= pr_s2.last ? '0 : acc_next;
		end
	end

	// Result register: load on a last pair, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
		end else if (consume && pr_s2.last) begin
			sum_valid_q <= 1'b1;
		end else if (sum_out.ready) begin
			sum_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && pr_s2.last) begin
			sum_q <= acc_ext[OUT_W-1:0];
		end
	end

	assign sum_out.valid   = sum_valid_q;
	assign sum_out.dot_sum = sum_q;

endmodule

`default_nettype wire

// File: rtl/sfdp_checker.sv
`default_nettype none
`include "saturating_fixed_point_dot_product_core_macros.svh"

module sfdp_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire sfdp_pkg::sum_t dot_sum
);
	// A pending result holds until its transfer
	`SFDP_ASSERT_NEXT(a_out_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SFDP_ASSERT_NEXT(a_out_data_hold, clk, arst_n, out_valid && !out_ready, $stable(dot_sum))
	// With the result register empty nothing stalls, so pairs are taken
	`SFDP_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	// Straight after reset the block is empty and ready
	`SFDP_ASSERT_IMPL(a_reset_empty, clk, arst_n, $past(!arst_n), !out_valid && in_ready)

endmodule

bind saturating_fixed_point_dot_product_core sfdp_checker u_sfdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pair_in.ready),
	.out_valid (sum_out.valid),
	.out_ready (sum_out.ready),
	.dot_sum   (sum_out.dot_sum)
);

`default_nettype wire

// File: tb/saturating_fixed_point_dot_product_core_test.sv
`default_nettype none

module saturating_fixed_point_dot_product_core_test;
	import sfdp_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_PAIRS  = 500;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_GAP       = 12;
	localparam int SHOWN_FAULTS  = 10;

	typedef logic signed [127:0] wide_t;

	// One row of the directed stimulus; want is only used where known is set
	typedef struct {
		weight_t weight;
		sample_t sample;
		logic    last;
		int      reps;
		logic    known;
		sum_t    want;
	} pair_row_t;

	logic clk;
	logic arst_n;

	sfdp_pair_if pair_if();
	sfdp_sum_if  sum_if();

	saturating_fixed_point_dot_product_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pair_in (pair_if),
		.sum_out (sum_if)
	);

	wide_t running_sum;
	sum_t  pending_sums[$];
	int    fault_count;
	int    cycle_count;
	int    pairs_sent;
	int    sums_checked;
	int    clamp_count;
	logic  src_quiet;
	logic  sink_quiet;

	pair_row_t directed_rows [17];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d sums outstanding",
				cycle_count, pending_sums.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Fold one pair into the running sum: align, add, round half to even, clamp
	function automatic sum_t fold_pair(weight_t w, sample_t s, logic fin);
		wide_t wv, sv, prod, total, q, rem, half, top, bottom;
		sum_t  result;
		wv   = (wide_t'(w) <<< (128 - WEIGHT_WIDTH)) >>> (128 - WEIGHT_WIDTH);
		sv   = (wide_t'(s) <<< (128 - DATA_WIDTH)) >>> (128 - DATA_WIDTH);
		prod = wv * sv;
		if (SHIFT > 0) begin
			total = (running_sum <<< POS_SH) + prod;
			q     = total >>> POS_SH;
			rem   = total - (q <<< POS_SH);
			half  = (wide_t'(1) <<< POS_SH) >>> 1;
			if (rem > half || (rem == half && q[0]))
				q = q + 1;
			total = q;
		end else begin
			total = running_sum + (prod <<< NEG_SH);
		end
		top    = (wide_t'(1) <<< (ACC_WIDTH - 1)) - 1;
		bottom = -top - 1;
		if (total > top) begin
			total = top;
			clamp_count++;
		end else if (total < bottom) begin
			total = bottom;
			clamp_count++;
		end
		running_sum = total;
		result      = total[OUT_W-1:0];
		if (fin)
			running_sum = '0;
		return result;
	endfunction

	task automatic log_fault(string what);
		fault_count++;
		if (fault_count <= SHOWN_FAULTS)
			$display("MISMATCH at cycle %0d: %s", cycle_count, what);
	endtask

	// Offer one pair after a random gap, hold it until the transfer, then predict
	task automatic send_pair(weight_t w, sample_t s, logic fin, logic known, sum_t want);
		int   gap;
		sum_t predicted;
		gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			pair_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pair_if.valid  <= 1'b1;
		pair_if.weight <= w;
		pair_if.sample <= s;
		pair_if.last   <= fin;
		do
			@(posedge clk);
		while (!(pair_if.valid && pair_if.ready));
		pairs_sent++;
		predicted = fold_pair(w, s, fin);
		if (fin)
			pending_sums.push_back(known ? want : predicted);
	endtask

	// Stop offering pairs until every outstanding sum has come back
	task automatic hold_until_drained();
		pair_if.valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	// Full-range random values, with a fair share of extremes and small ones for ties
	function automatic logic [15:0] pick_operand();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'hFFFF;
			3: v = 16'h0000;
			4, 5: begin
				v = 16'($urandom_range(0, 48));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Sum side: stall at random, take each transfer and compare it
	initial begin
		int   stall;
		sum_t want;
		sum_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				sum_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			sum_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!(sum_if.valid && sum_if.ready));
			sums_checked++;
			if (pending_sums.size() == 0) begin
				log_fault($sformatf("unexpected dot_sum 0x%08h", sum_if.dot_sum));
			end else begin
				want = pending_sums.pop_front();
				if (sum_if.dot_sum !== want)
					log_fault($sformatf("dot_sum expected 0x%08h got 0x%08h",
						want, sum_if.dot_sum));
			end
		end
	end

	// Pair side: reset, directed rows, then random dot products
	initial begin
		int      len;
		int      sent_random;
		logic    paused_midway;
		logic    run_sign;
		weight_t w;
		sample_t s;

		running_sum   = '0;
		fault_count   = 0;
		pairs_sent    = 0;
		sums_checked  = 0;
		clamp_count   = 0;
		src_quiet     = 1'b0;
		sink_quiet    = 1'b0;
		sent_random   = 0;
		paused_midway = 1'b0;

		directed_rows = '{
			// zero straight after reset
			'{16'sh0000, 16'sh0000, 1'b1, 1,  1'b1, 32'sd0},
			// product below half an output step rounds down
			'{16'sh0001, 16'sh0001, 1'b1, 1,  1'b1, 32'sd0},
			// exact ties go to the even neighbour, both signs
			'{16'sh0008, 16'sh0001, 1'b1, 1,  1'b1, 32'sd0},
			'{16'sh0018, 16'sh0001, 1'b1, 1,  1'b1, 32'sd2},
			'{-16'sh0008, 16'sh0001, 1'b1, 1, 1'b1, 32'sd0},
			'{-16'sh0018, 16'sh0001, 1'b1, 1, 1'b1, -32'sd2},
			// operand extremes
			'{16'sh7FFF, 16'sh7FFF, 1'b1, 1,  1'b1, 32'sd67104768},
			'{16'sh8000, 16'sh8000, 1'b1, 1,  1'b1, 32'sd67108864},
			'{16'sh8000, 16'sh7FFF, 1'b1, 1,  1'b1, -32'sd67106816},
			'{16'sh7FFF, 16'sh8000, 1'b0, 1,  1'b0, 32'sd0},
			'{16'sh7FFF, 16'sh8000, 1'b1, 1,  1'b0, 32'sd0},
			// thirty-two largest products clamp at the top
			'{16'sh8000, 16'sh8000, 1'b0, 31, 1'b0, 32'sd0},
			'{16'sh8000, 16'sh8000, 1'b1, 1,  1'b1, 32'sh7FFFFFFF},
			// accumulator starts clean after a clamped sum
			'{16'sh0010, 16'sh0001, 1'b1, 1,  1'b1, 32'sd1},
			// mixed bit patterns
			'{16'sh5A5A, 16'shA5A5, 1'b0, 1,  1'b0, 32'sd0},
			'{16'sh1234, 16'sh8001, 1'b0, 1,  1'b0, 32'sd0},
			'{16'shFFFF, 16'shFFFF, 1'b1, 1,  1'b0, 32'sd0}
		};

		arst_n         <= 1'b0;
		pair_if.valid  <= 1'b0;
		pair_if.weight <= '0;
		pair_if.sample <= '0;
		pair_if.last   <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[i]) begin
			for (int r = 0; r < directed_rows[i].reps; r++)
				send_pair(directed_rows[i].weight, directed_rows[i].sample,
					directed_rows[i].last, directed_rows[i].known, directed_rows[i].want);
		end
		hold_until_drained();

		// Random dot products; now and then a long run of extreme products to clamp
		while (sent_random < RANDOM_PAIRS) begin
			if ($urandom_range(0, 7) == 0)
				src_quiet = ~src_quiet;
			if ($urandom_range(0, 7) == 0)
				sink_quiet = ~sink_quiet;
			if ($urandom_range(0, 19) == 0) begin
				len      = $urandom_range(34, 40);
				run_sign = $urandom_range(0, 1);
				for (int k = 0; k < len; k++)
					send_pair(16'sh8000, run_sign ? 16'sh8000 : 16'sh7FFF,
						k == len - 1, 1'b0, '0);
			end else begin
				len = $urandom_range(1, 8);
				for (int k = 0; k < len; k++) begin
					w = pick_operand();
					s = pick_operand();
					send_pair(w, s, k == len - 1, 1'b0, '0);
				end
			end
			sent_random += len;
			if (!paused_midway && sent_random >= RANDOM_PAIRS / 2) begin
				paused_midway = 1'b1;
				hold_until_drained();
			end
		end

		// Drain, then allow the pipeline to settle
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_sums.size() != 0)
			log_fault($sformatf("%0d sums never arrived", pending_sums.size()));

		$display("Streamed %0d operand pairs into %0d dot products under random idling",
			pairs_sent, sums_checked);
		$display("on both sides; %0d accumulate steps clamped at a bound.", clamp_count);
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches in total", fault_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/sfdp_pkg.sv
rtl/sfdp_if.sv
rtl/saturating_fixed_point_dot_product_core.sv
rtl/sfdp_checker.sv
tb/saturating_fixed_point_dot_product_core_test.sv
